// ===== src/sdspi_pkg.sv =====
`default_nettype none

package sdspi_pkg;

    // item operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_RECEIVE = 1'b1;

    // bus constants
    localparam logic [7:0] BYTE_FILL     = 8'hFF;
    localparam logic [6:0] CRC7_POLY     = 7'h09;
    localparam logic [2:0] TOKEN_CRC_POS = 3'd5;

    // transaction phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_READY = 4'b0010,
        PH_TOKEN = 4'b0100,
        PH_RESP  = 4'b1000
    } t_phase;

    // fold one byte into a crc7, msb first
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
        logic [6:0] crc;
        logic       fb;
        crc = crc_in;
        for (int b = 0; b < 8; b++) begin
            fb  = crc[6] ^ data[7 - b];
            crc = {crc[5:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC7_POLY;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== src/sd_spi_command_transaction_core.sv =====
// SD card SPI command sequencer, one SPI byte exchange per item.
// Input channel (i_valid / o_stall): an item is either a start request
// (i_operation = 0, with command byte and argument) or the byte the card
// returned in the last exchange (i_operation = 1, with received byte).
// Output channel (o_valid / i_stall): exactly one result item per input item,
// giving the next byte to shift out (when o_transmit_valid is set) or the
// captured R1 response (when o_done_res is set).
// An input register feeds the phase logic, which feeds the result register.
// One item is taken every cycle when not stalled; the CRC7 is folded one
// token byte per exchange so each step is a single byte-wide crc update.
// When the receiver stalls, the result register holds and o_stall rises
// only once the input register is also full, so one item waits in each.
// Reset (synchronous, active low) empties both registers and returns the
// sequencer to idle; start items while busy and received bytes while idle
// give an all-zero result.
`default_nettype none

module sd_spi_command_transaction_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_operation,
    input  wire logic [7:0]  i_command_byte,
    input  wire logic [31:0] i_argument,
    input  wire logic [7:0]  i_received_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_transmit_valid,
    output logic [7:0]       o_transmit_byte,
    output logic             o_done_res,
    output logic [7:0]       o_response
);
    import sdspi_pkg::*;

    // input register
    logic        r_in_valid;
    logic        r_op;
    logic [7:0]  r_cmd_in;
    logic [31:0] r_arg_in;
    logic [7:0]  r_rx;

    // transaction state
    t_phase      r_phase,  n_phase;
    logic [2:0]  r_token_index, n_token_index;
    logic [7:0]  r_held_command, n_held_command;
    logic [31:0] r_held_argument, n_held_argument;
    logic [6:0]  r_crc, n_crc;

    // result register
    logic        r_out_valid;
    logic        r_tv, n_tv;
    logic [7:0]  r_tb, n_tb;
    logic        r_dn, n_dn;
    logic [7:0]  r_rsp, n_rsp;

    logic        advance;
    logic        process;
    logic [7:0]  token_sel;

    // handshake: result register free or being emptied
    assign advance = !r_out_valid || !i_stall;
    assign process = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    // token byte for the current index
    always_comb begin
        unique case (r_token_index)
            3'd0:    token_sel = r_held_command;
            3'd1:    token_sel = r_held_argument[31:24];
            3'd2:    token_sel = r_held_argument[23:16];
            3'd3:    token_sel = r_held_argument[15:8];
            3'd4:    token_sel = r_held_argument[7:0];
            default: token_sel = {r_crc, 1'b1};
        endcase
    end

    // phase logic for one item
    always_comb begin
        n_phase         = r_phase;
        n_token_index   = r_token_index;
        n_held_command  = r_held_command;
        n_held_argument = r_held_argument;
        n_crc           = r_crc;
        n_tv            = 1'b0;
        n_tb            = 8'h00;
        n_dn            = 1'b0;
        n_rsp           = 8'h00;
        if (r_op == OP_START) begin
            if (r_phase == PH_IDLE) begin
                n_held_command  = r_cmd_in;
                n_held_argument = r_arg_in;
                n_token_index   = 3'd0;
                n_phase         = PH_READY;
                n_tv            = 1'b1;
                n_tb            = BYTE_FILL;
            end
        end else begin
            unique case (r_phase)
                PH_READY: begin
                    n_tv = 1'b1;
                    if (r_rx == BYTE_FILL) begin
                        n_tb          = r_held_command;
                        n_crc         = crc7_byte(7'd0, r_held_command);
                        n_token_index = 3'd1;
                        n_phase       = PH_TOKEN;
                    end else begin
                        n_tb = BYTE_FILL;
                    end
                end
                PH_TOKEN: begin
                    n_tv = 1'b1;
                    if (r_token_index <= TOKEN_CRC_POS) begin
                        n_tb          = token_sel;
                        n_token_index = r_token_index + 3'd1;
                        if (r_token_index < TOKEN_CRC_POS) begin
                            n_crc = crc7_byte(r_crc, token_sel);
                        end
                    end else begin
                        n_tb    = BYTE_FILL;
                        n_phase = PH_RESP;
                    end
                end
                PH_RESP: begin
                    if (r_rx[7]) begin
                        n_tv = 1'b1;
                        n_tb = BYTE_FILL;
                    end else begin
                        n_dn          = 1'b1;
                        n_rsp         = r_rx;
                        n_phase       = PH_IDLE;
                        n_token_index = 3'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_IDLE;
            r_token_index <= 3'd0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (process) begin
                r_phase       <= n_phase;
                r_token_index <= n_token_index;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_op     <= i_operation;
            r_cmd_in <= i_command_byte;
            r_arg_in <= i_argument;
            r_rx     <= i_received_byte;
        end
        if (process) begin
            r_held_command  <= n_held_command;
            r_held_argument <= n_held_argument;
            r_crc           <= n_crc;
            r_tv            <= n_tv;
            r_tb            <= n_tb;
            r_dn            <= n_dn;
            r_rsp           <= n_rsp;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_transmit_valid = r_tv;
    assign o_transmit_byte  = r_tb;
    assign o_done_res       = r_dn;
    assign o_response       = r_rsp;

    // a captured response never asks for another exchange
    a_done_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> !o_transmit_valid)
        else $error("response result also requests a transfer");

    // token index stays within the token while sending it
    a_token_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TOKEN) |-> (r_token_index != 3'd0 && r_token_index <= 3'd6))
        else $error("token index out of range");

    // idle always has a cleared token index
    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_token_index == 3'd0))
        else $error("token index not cleared in idle");

    // a response byte with bit 7 clear ends the transaction
    a_resp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_op == OP_RECEIVE && r_phase == PH_RESP && !r_rx[7])
        |=> (r_phase == PH_IDLE && o_valid && o_done_res))
        else $error("response did not close the transaction");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    import sdspi_pkg::*;

    // one result item as the block reports it
    typedef struct packed {
        logic       tv;
        logic [7:0] tb;
        logic       dn;
        logic [7:0] rsp;
    } t_spi_result;

    // one row of the directed stimulus table
    typedef struct {
        logic        op;
        logic [7:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  rx;
        bit          typed;
        t_spi_result res;
    } t_stim_row;

    localparam int RANDOM_ITEMS   = 500;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    localparam t_spi_result NO_RESULT = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_operation;
    logic [7:0]  i_command_byte;
    logic [31:0] i_argument;
    logic [7:0]  i_received_byte;
    logic        o_valid;
    logic        i_stall;
    logic        o_transmit_valid;
    logic [7:0]  o_transmit_byte;
    logic        o_done_res;
    logic [7:0]  o_response;

    // shadow of the command sequencer
    t_phase      seq_phase;
    logic [2:0]  seq_token_idx;
    logic [7:0]  seq_cmd;
    logic [31:0] seq_arg;
    logic [6:0]  seq_crc;

    t_spi_result exchange_q[$];
    t_stim_row   dir_rows[$];
    int          mismatch_cnt = 0;
    int          stuck_cycles = 0;
    bit          quiet;
    bit          hold_req;

    sd_spi_command_transaction_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_command_byte   (i_command_byte),
        .i_argument       (i_argument),
        .i_received_byte  (i_received_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_transmit_valid (o_transmit_valid),
        .o_transmit_byte  (o_transmit_byte),
        .o_done_res       (o_done_res),
        .o_response       (o_response)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // crc7 over the 40 header bits, msb first
    function automatic logic [6:0] header_crc7(input logic [39:0] hdr);
        logic [6:0] c;
        c = 7'h00;
        for (int i = 39; i >= 0; i--) begin
            c = {c[5:0], 1'b0} ^ ((c[6] ^ hdr[i]) ? CRC7_POLY : 7'h00);
        end
        return c;
    endfunction

    // result that asks for one more exchange
    function automatic t_spi_result tx_res(input logic [7:0] b);
        return {1'b1, b, 1'b0, 8'h00};
    endfunction

    // result that reports the captured response
    function automatic t_spi_result rsp_res(input logic [7:0] b);
        return {1'b0, 8'h00, 1'b1, b};
    endfunction

    // advance the shadow sequencer by one item, give the exchange it causes
    function automatic t_spi_result sequence_step(input logic op, input logic [7:0] cmd,
                                                  input logic [31:0] arg, input logic [7:0] rx);
        t_spi_result r;
        r = '0;
        if (op == OP_START) begin
            if (seq_phase == PH_IDLE) begin
                seq_cmd       = cmd;
                seq_arg       = arg;
                seq_crc       = header_crc7({cmd, arg});
                seq_token_idx = 3'd0;
                seq_phase     = PH_READY;
                r.tv          = 1'b1;
                r.tb          = BYTE_FILL;
            end
        end else begin
            case (seq_phase)
                PH_READY: begin
                    r.tv = 1'b1;
                    if (rx == BYTE_FILL) begin
                        r.tb          = seq_cmd;
                        seq_token_idx = 3'd1;
                        seq_phase     = PH_TOKEN;
                    end else begin
                        r.tb = BYTE_FILL;
                    end
                end
                PH_TOKEN: begin
                    r.tv = 1'b1;
                    if (seq_token_idx <= TOKEN_CRC_POS) begin
                        case (seq_token_idx)
                            3'd1:    r.tb = seq_arg[31:24];
                            3'd2:    r.tb = seq_arg[23:16];
                            3'd3:    r.tb = seq_arg[15:8];
                            3'd4:    r.tb = seq_arg[7:0];
                            default: r.tb = {seq_crc, 1'b1};
                        endcase
                        seq_token_idx = seq_token_idx + 3'd1;
                    end else begin
                        // token exhausted, byte after the crc is dropped
                        r.tb      = BYTE_FILL;
                        seq_phase = PH_RESP;
                    end
                end
                PH_RESP: begin
                    if (rx[7]) begin
                        r.tv = 1'b1;
                        r.tb = BYTE_FILL;
                    end else begin
                        r.dn          = 1'b1;
                        r.rsp         = rx;
                        seq_phase     = PH_IDLE;
                        seq_token_idx = 3'd0;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic t_stim_row mk_row(input logic op, input logic [7:0] cmd,
                                         input logic [31:0] arg, input logic [7:0] rx,
                                         input bit typed, input t_spi_result res);
        t_stim_row row;
        row.op    = op;
        row.cmd   = cmd;
        row.arg   = arg;
        row.rx    = rx;
        row.typed = typed;
        row.res   = res;
        return row;
    endfunction

    // offer one item, predict on acceptance, then maybe idle
    task automatic send_item(input logic op, input logic [7:0] cmd, input logic [31:0] arg,
                             input logic [7:0] rx, input bit typed,
                             input t_spi_result typed_res, output t_spi_result pred);
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_command_byte  <= cmd;
        i_argument      <= arg;
        i_received_byte <= rx;
        do @(posedge i_clk); while (o_stall);
        pred = sequence_step(op, cmd, arg, rx);
        exchange_q.push_back(typed ? typed_res : pred);
        if (!quiet) begin
            while ($urandom_range(99) < 27) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
    endtask

    task automatic wait_drain();
        while (exchange_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall, random, with one long hold-off
    initial begin
        int hold_cnt;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    hold_cnt++;
                end
            end else begin
                i_stall <= !quiet && ($urandom_range(99) < 27);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_spi_result got;
        t_spi_result want;
        got = {o_transmit_valid, o_transmit_byte, o_done_res, o_response};
        if (i_rst_n && o_valid && !i_stall) begin
            if (exchange_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected result item: tv=%0b tb=%02h done=%0b rsp=%02h",
                             got.tv, got.tb, got.dn, got.rsp);
                end
            end else begin
                want = exchange_q.pop_front();
                if (got.tv !== want.tv || got.tb !== want.tb ||
                    got.dn !== want.dn || got.rsp !== want.rsp) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display({"mismatch: exp tv=%0b tb=%02h done=%0b rsp=%02h,",
                                  " got tv=%0b tb=%02h done=%0b rsp=%02h"},
                                 want.tv, want.tb, want.dn, want.rsp,
                                 got.tv, got.tb, got.dn, got.rsp);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_spi_result pred;
        logic        op;
        logic [7:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  rx;
        int          active_cnt;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_operation     = OP_START;
        i_command_byte  = 8'h00;
        i_argument      = 32'h0;
        i_received_byte = 8'h00;
        quiet           = 1'b0;
        hold_req        = 1'b0;
        seq_phase       = PH_IDLE;
        seq_token_idx   = 3'd0;
        seq_cmd         = 8'h00;
        seq_arg         = 32'h0;
        seq_crc         = 7'h00;

        // directed table: go-idle command, then extremes and ignored items
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'hFF, 1'b1, NO_RESULT));
        dir_rows.push_back(mk_row(OP_START,   8'h40, 32'h0,        8'h00, 1'b1, tx_res(8'hFF)));
        dir_rows.push_back(mk_row(OP_START,   8'hFF, 32'hFFFFFFFF, 8'h00, 1'b1, NO_RESULT));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'h00, 1'b1, tx_res(8'hFF)));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'hFF, 1'b1, tx_res(8'h40)));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'h12, 1'b1, tx_res(8'h00)));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'h34, 1'b1, tx_res(8'h00)));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'h56, 1'b1, tx_res(8'h00)));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'h78, 1'b1, tx_res(8'h00)));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'h9A, 1'b1, tx_res(8'h95)));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'hBC, 1'b1, tx_res(8'hFF)));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'h80, 1'b1, tx_res(8'hFF)));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'h01, 1'b1, rsp_res(8'h01)));
        dir_rows.push_back(mk_row(OP_START,   8'hFF, 32'hFFFFFFFF, 8'hFF, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'hFF, 32'hFFFFFFFF, 8'hFF, 1'b0, NO_RESULT));
        for (int k = 0; k < 5; k++) begin
            dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0, 8'h00, 1'b0, NO_RESULT));
        end
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'hAA, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'h00, 1'b1, rsp_res(8'h00)));
        dir_rows.push_back(mk_row(OP_START,   8'h48, 32'h000001AA, 8'h00, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'h7F, 1'b0, NO_RESULT));
        dir_rows.push_back(mk_row(OP_RECEIVE, 8'h00, 32'h0,        8'hFF, 1'b0, NO_RESULT));

        // reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            send_item(dir_rows[n].op, dir_rows[n].cmd, dir_rows[n].arg, dir_rows[n].rx,
                      dir_rows[n].typed, dir_rows[n].res, pred);
        end

        // sender pause until the pipeline is empty
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drain();

        // random transactions, mostly well formed, some noise
        active_cnt = 0;
        while (active_cnt < RANDOM_ITEMS) begin
            if (active_cnt == 150) begin
                quiet    = 1'b1;
                hold_req = 1'b1;
            end
            if (active_cnt == 250) begin
                quiet = 1'b0;
            end
            if (active_cnt == 350) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                wait_drain();
            end
            if (seq_phase == PH_IDLE) begin
                op = ($urandom_range(9) == 0) ? OP_RECEIVE : OP_START;
            end else begin
                op = ($urandom_range(19) == 0) ? OP_START : OP_RECEIVE;
            end
            cmd = 8'($urandom);
            arg = $urandom;
            rx  = 8'($urandom);
            if ($urandom_range(1) != 0) begin
                cmd[7:6] = 2'b01;
            end
            case (seq_phase)
                PH_READY: if ($urandom_range(99) < 60) rx = BYTE_FILL;
                PH_RESP:  rx[7] = 1'($urandom_range(1));
                default:  ;
            endcase
            send_item(op, cmd, arg, rx, 1'b0, NO_RESULT, pred);
            if (pred != NO_RESULT) begin
                active_cnt++;
            end
        end

        // wind down
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/sdspi_pkg.sv
src/sd_spi_command_transaction_core.sv
tb/tb.sv
